[src/u8u16_pkg.sv]
`default_nettype none

package u8u16_pkg;

    // unit counter width and the width used to compare it with the capacity
    localparam int COUNT_WIDTH = 16;
    localparam int CMP_W       = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
    localparam int TOTAL_W     = 16;

    // result queue depth
    localparam int QDEPTH = 4;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // configuration register indexes
    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_ENABLE   = 1'b1;

    // input kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // utf-8 lead and boundary bytes
    localparam logic [7:0] ASCII_MAX  = 8'h7f;
    localparam logic [7:0] LEAD2_MIN  = 8'hc2;
    localparam logic [7:0] LEAD2_MAX  = 8'hdf;
    localparam logic [7:0] LEAD3_MIN  = 8'he0;
    localparam logic [7:0] LEAD3_MAX  = 8'hef;
    localparam logic [7:0] LEAD4_MIN  = 8'hf0;
    localparam logic [7:0] LEAD4_MAX  = 8'hf4;
    localparam logic [7:0] LEAD_E0    = 8'he0;
    localparam logic [7:0] LEAD_ED    = 8'hed;
    localparam logic [7:0] LEAD_F0    = 8'hf0;
    localparam logic [7:0] LEAD_F4    = 8'hf4;
    localparam logic [7:0] CONT_A0    = 8'ha0;
    localparam logic [7:0] CONT_90    = 8'h90;

    // scalar limits and surrogate bases
    localparam logic [20:0] SCALAR_MAX = 21'h10ffff;
    localparam logic [20:0] BMP_MAX    = 21'h00ffff;
    localparam logic [20:0] SUPP_BASE  = 21'h010000;
    localparam logic [20:0] SURR_LO    = 21'h00d800;
    localparam logic [20:0] SURR_HI    = 21'h00dfff;
    localparam logic [15:0] HIGH_SURR  = 16'hd800;
    localparam logic [15:0] LOW_SURR   = 16'hdc00;

    typedef enum logic [1:0] {
        ST_UNIT     = 2'd0,
        ST_DONE     = 2'd1,
        ST_INVALID  = 2'd2,
        ST_TOOSMALL = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [20:0] scalar;
        logic [2:0]  seq_bytes;
        t_status     status;
        logic [15:0] unit_total;
        logic        last;
    } t_item;

    // results caused by one input item
    typedef struct packed {
        logic [1:0] cnt;
        t_item      item0;
        t_item      item1;
    } t_res_pair;

    // unit count as shown on the result, saturated at 16 bits
    function automatic logic [TOTAL_W-1:0] shown_total(input logic [COUNT_WIDTH-1:0] c);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(c);
        if (ext > CMP_W'(17'h0ffff)) begin
            shown_total = 16'hffff;
        end else begin
            shown_total = ext[TOTAL_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

[src/utf8_to_utf16_transcoder.sv]
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+----------------------------------------
// input     | in        | i_valid / o_stall       | i_kind, i_in_byte
// result    | out       | o_valid / i_stall       | o_code_unit, o_scalar, o_seq_bytes,
//           |           |                         | o_status, o_unit_total, o_last
// config    | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// one byte per cycle while o_stall is low: decode and counting finish in the cycle the
// item is taken, and its results land in a four-entry result queue, visible the next cycle
// a four-byte scalar outside the bmp yields two results over four input items, and the
// queue drains one per cycle while i_stall is low, so it never holds back input on its own
// o_stall rises when fewer than two queue entries are free, which only i_stall causes
// synchronous active-low reset empties the queue; capacity 65535, transcoding on
`default_nettype none

module utf8_to_utf16_transcoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input items
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_kind,
    input  wire  [7:0]  i_in_byte,
    // result items
    output logic        o_valid,
    input  wire         i_stall,
    output logic [15:0] o_code_unit,
    output logic [20:0] o_scalar,
    output logic [2:0]  o_seq_bytes,
    output logic [1:0]  o_status,
    output logic [15:0] o_unit_total,
    output logic        o_last,
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    localparam int QD = u8u16_pkg::QDEPTH;
    localparam int QW = u8u16_pkg::QCNT_W;

    // configuration registers
    logic [15:0] r_capacity;
    logic        r_enable;

    // result queue, entry 0 is the head
    u8u16_pkg::t_item r_q [QD];
    u8u16_pkg::t_item n_q [QD];
    logic [QW-1:0]    r_count, n_count;

    u8u16_pkg::t_res_pair res;
    logic                 take;
    logic                 pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 16'hffff;
            r_enable   <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                u8u16_pkg::CFG_CAPACITY: r_capacity <= i_cfg_data;
                u8u16_pkg::CFG_ENABLE:   r_enable   <= i_cfg_data[0];
                default:                 r_enable   <= r_enable;
            endcase
        end
    end

    // stall depends only on the registered fill level
    assign o_stall = (r_count > QW'(QD - 2));
    assign take    = i_valid && !o_stall;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;

    // byte decode, validation and unit counting
    u8u16_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_kind     (i_kind),
        .i_in_byte  (i_in_byte),
        .i_capacity (r_capacity),
        .i_enable   (r_enable),
        .o_res      (res)
    );

    // shift on pop, then place new results right after the remaining entries
    always_comb begin
        logic [QW-1:0] base;
        logic [1:0]    push_n;
        base   = r_count - (pop ? QW'(1) : QW'(0));
        push_n = take ? res.cnt : 2'd0;
        for (int i = 0; i < QD; i++) begin
            if (pop && i < QD - 1) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (push_n != 2'd0 && QW'(i) == base) begin
                n_q[i] = res.item0;
            end
            if (push_n == 2'd2 && QW'(i) == base + QW'(1)) begin
                n_q[i] = res.item1;
            end
        end
        n_count = base + QW'(push_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QD; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign o_code_unit  = r_q[0].code_unit;
    assign o_scalar     = r_q[0].scalar;
    assign o_seq_bytes  = r_q[0].seq_bytes;
    assign o_status     = r_q[0].status;
    assign o_unit_total = r_q[0].unit_total;
    assign o_last       = r_q[0].last;

`ifndef SYNTH
    // queue never overfills
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QW'(QD))
        else $error("result queue overfilled");

    // status items always close out their input item
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != u8u16_pkg::ST_UNIT) |-> o_last)
        else $error("status item without last");

    // first half of a pair is a high surrogate, followed by a low surrogate
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_code_unit[15:10] == 6'b110110 &&
            r_count >= QW'(2) && r_q[1].code_unit[15:10] == 6'b110111))
        else $error("broken surrogate pair");
`endif

endmodule

`default_nettype wire

[src/u8u16_decode.sv]
`default_nettype none

module u8u16_decode (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_take,
    input  wire                i_kind,
    input  wire [7:0]          i_in_byte,
    input  wire [15:0]         i_capacity,
    input  wire                i_enable,
    output u8u16_pkg::t_res_pair o_res
);

    localparam int CW = u8u16_pkg::COUNT_WIDTH;
    localparam int MW = u8u16_pkg::CMP_W;

    logic [20:0]   r_accum, n_accum;
    logic [1:0]    r_left,  n_left;
    logic [7:0]    r_lead,  n_lead;
    logic [2:0]    r_len,   n_len;
    logic [CW-1:0] r_count, n_count;
    logic          r_failed, n_failed;
    logic          r_dropped, n_dropped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum   <= '0;
            r_left    <= '0;
            r_lead    <= '0;
            r_len     <= '0;
            r_count   <= '0;
            r_failed  <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            r_accum   <= n_accum;
            r_left    <= n_left;
            r_lead    <= n_lead;
            r_len     <= n_len;
            r_count   <= n_count;
            r_failed  <= n_failed;
            r_dropped <= n_dropped;
        end
    end

    always_comb begin
        logic        fin_go;
        logic [20:0] fin_sc;
        logic [2:0]  fin_n;
        logic        err;
        logic        first;
        logic [20:0] acc_new;
        logic [20:0] adj;
        logic        two;
        logic [CW:0] sum1, sum2;
        logic [CW-1:0] c1, c2;
        logic        fits;
        u8u16_pkg::t_status st;

        n_accum   = r_accum;
        n_left    = r_left;
        n_lead    = r_lead;
        n_len     = r_len;
        n_count   = r_count;
        n_failed  = r_failed;
        n_dropped = r_dropped;
        o_res     = '0;
        fin_go    = 1'b0;
        fin_sc    = '0;
        fin_n     = '0;
        err       = 1'b0;
        first     = ((r_len - {1'b0, r_left}) == 3'd1);
        acc_new   = {r_accum[14:0], i_in_byte[5:0]};
        adj       = '0;
        two       = 1'b0;
        sum1      = '0;
        sum2      = '0;
        c1        = '0;
        c2        = '0;
        fits      = 1'b0;
        st        = u8u16_pkg::ST_DONE;

        if (i_take) begin
            if (i_kind == u8u16_pkg::KIND_END) begin
                if (!r_failed) begin
                    if (r_left != 2'd0) begin
                        st = u8u16_pkg::ST_INVALID;
                    end else if (r_dropped && i_enable) begin
                        st = u8u16_pkg::ST_TOOSMALL;
                    end else begin
                        st = u8u16_pkg::ST_DONE;
                    end
                    o_res.cnt              = 2'd1;
                    o_res.item0.status     = st;
                    o_res.item0.unit_total = u8u16_pkg::shown_total(r_count);
                    o_res.item0.last       = 1'b1;
                end
                // end of text rearms the block
                n_accum   = '0;
                n_left    = '0;
                n_lead    = '0;
                n_len     = '0;
                n_count   = '0;
                n_failed  = 1'b0;
                n_dropped = 1'b0;
            end else if (!r_failed) begin
                if (r_left == 2'd0) begin
                    if (i_in_byte <= u8u16_pkg::ASCII_MAX) begin
                        fin_go = 1'b1;
                        fin_sc = {13'd0, i_in_byte};
                        fin_n  = 3'd1;
                    end else if (i_in_byte inside {[u8u16_pkg::LEAD2_MIN:u8u16_pkg::LEAD2_MAX]})
                    begin
                        n_len   = 3'd2;
                        n_left  = 2'd1;
                        n_accum = {16'd0, i_in_byte[4:0]};
                        n_lead  = i_in_byte;
                    end else if (i_in_byte inside {[u8u16_pkg::LEAD3_MIN:u8u16_pkg::LEAD3_MAX]})
                    begin
                        n_len   = 3'd3;
                        n_left  = 2'd2;
                        n_accum = {17'd0, i_in_byte[3:0]};
                        n_lead  = i_in_byte;
                    end else if (i_in_byte inside {[u8u16_pkg::LEAD4_MIN:u8u16_pkg::LEAD4_MAX]})
                    begin
                        n_len   = 3'd4;
                        n_left  = 2'd3;
                        n_accum = {18'd0, i_in_byte[2:0]};
                        n_lead  = i_in_byte;
                    end else begin
                        err = 1'b1;
                    end
                end else begin
                    if (i_in_byte[7:6] != 2'b10) begin
                        err = 1'b1;
                    end else if (first &&
                        ((r_lead == u8u16_pkg::LEAD_E0 && i_in_byte <  u8u16_pkg::CONT_A0) ||
                         (r_lead == u8u16_pkg::LEAD_ED && i_in_byte >= u8u16_pkg::CONT_A0) ||
                         (r_lead == u8u16_pkg::LEAD_F0 && i_in_byte <  u8u16_pkg::CONT_90) ||
                         (r_lead == u8u16_pkg::LEAD_F4 && i_in_byte >= u8u16_pkg::CONT_90)))
                    begin
                        err = 1'b1;
                    end else begin
                        n_accum = acc_new;
                        n_left  = r_left - 2'd1;
                        if (r_left == 2'd1) begin
                            fin_go = 1'b1;
                            fin_sc = acc_new;
                            fin_n  = r_len;
                        end
                    end
                end
            end
        end

        if (fin_go) begin
            n_left  = '0;
            n_len   = '0;
            n_accum = '0;
            if (fin_sc > u8u16_pkg::SCALAR_MAX ||
                (fin_sc >= u8u16_pkg::SURR_LO && fin_sc <= u8u16_pkg::SURR_HI)) begin
                err = 1'b1;
            end else begin
                two  = (fin_sc > u8u16_pkg::BMP_MAX);
                sum1 = {1'b0, r_count} + (CW+1)'(1);
                sum2 = {1'b0, r_count} + (two ? (CW+1)'(2) : (CW+1)'(1));
                c1   = sum1[CW] ? {CW{1'b1}} : sum1[CW-1:0];
                c2   = sum2[CW] ? {CW{1'b1}} : sum2[CW-1:0];
                fits = (MW'(sum2) <= MW'(i_capacity));
                n_count = c2;
                if (!fits) begin
                    n_dropped = 1'b1;
                end
                if (i_enable && fits) begin
                    o_res.item0.scalar    = fin_sc;
                    o_res.item0.seq_bytes = fin_n;
                    o_res.item0.status    = u8u16_pkg::ST_UNIT;
                    o_res.item0.unit_total = u8u16_pkg::shown_total(c1);
                    if (!two) begin
                        o_res.cnt             = 2'd1;
                        o_res.item0.code_unit = fin_sc[15:0];
                        o_res.item0.last      = 1'b1;
                    end else begin
                        adj = fin_sc - u8u16_pkg::SUPP_BASE;
                        o_res.cnt              = 2'd2;
                        o_res.item0.code_unit  = u8u16_pkg::HIGH_SURR | {6'd0, adj[19:10]};
                        o_res.item0.last       = 1'b0;
                        o_res.item1.code_unit  = u8u16_pkg::LOW_SURR | {6'd0, adj[9:0]};
                        o_res.item1.scalar     = fin_sc;
                        o_res.item1.seq_bytes  = fin_n;
                        o_res.item1.status     = u8u16_pkg::ST_UNIT;
                        o_res.item1.unit_total = u8u16_pkg::shown_total(c2);
                        o_res.item1.last       = 1'b1;
                    end
                end
            end
        end

        if (err) begin
            n_failed = 1'b1;
            n_left   = '0;
            n_len    = '0;
            n_accum  = '0;
            o_res    = '0;
            o_res.cnt              = 2'd1;
            o_res.item0.status     = u8u16_pkg::ST_INVALID;
            o_res.item0.unit_total = u8u16_pkg::shown_total(r_count);
            o_res.item0.last       = 1'b1;
        end
    end

endmodule

`default_nettype wire

[tb/sv/utf8_to_utf16_transcoder_tb.sv]
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_tb;

    // run limits
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_LIMIT = 20_000;
    localparam int SETTLE_CYCLES = 8;      // queue latency plus margin before a register write
    localparam int LONG_HOLD = 300;        // receiver hold-off that fills the result queue
    localparam int PHASE_ITEMS = 100;      // items per register setting
    localparam int LAST_ITEMS = 80;        // items in the closing part with no idling
    localparam int MAX_PRINTS = 40;

    // unicode boundaries used by the predictor
    localparam logic [20:0] UNICODE_MAX     = 21'h10ffff;
    localparam logic [20:0] BMP_LAST        = 21'h00ffff;
    localparam logic [20:0] PLANE1_START    = 21'h010000;
    localparam logic [20:0] SURROGATE_FIRST = 21'h00d800;
    localparam logic [20:0] SURROGATE_LAST  = 21'h00dfff;
    localparam logic [32:0] COUNT_LIMIT     = (33'd1 << u8u16_pkg::COUNT_WIDTH) - 33'd1;

    // one row of the directed table
    typedef struct {
        logic              kind;
        logic [7:0]        data;
        bit                typed;
        u8u16_pkg::t_item  want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_kind;
    logic [7:0]  i_in_byte;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_code_unit;
    logic [20:0] o_scalar;
    logic [2:0]  o_seq_bytes;
    logic [1:0]  o_status;
    logic [15:0] o_unit_total;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    utf8_to_utf16_transcoder uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_in_byte    (i_in_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_code_unit  (o_code_unit),
        .o_scalar     (o_scalar),
        .o_seq_bytes  (o_seq_bytes),
        .o_status     (o_status),
        .o_unit_total (o_unit_total),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // predictor copy of the registers
    logic [15:0] cap_reg = 16'hffff;
    logic        xcode_en = 1'b1;

    // predictor copy of the decoder state
    logic [20:0] acc = '0;
    logic [1:0]  left = '0;
    logic [7:0]  lead = '0;
    logic [2:0]  slen = '0;
    logic [32:0] ucount = '0;
    bit          failed_text = 1'b0;
    bit          dropped_text = 1'b0;

    // expected utf-16 results, oldest first
    u8u16_pkg::t_item utf16_expected[$];

    // directed rows can carry a typed expectation for the item on offer
    bit               row_typed = 1'b0;
    u8u16_pkg::t_item row_want;

    // run control shared by the driver and the stall process
    bit idle_on = 1'b0;
    bit hold_req = 1'b0;

    // bookkeeping
    int               mismatch_count = 0;
    int               results_seen = 0;
    int               items_taken = 0;
    int               texts_sent = 0;
    int               settings_used = 0;
    int               units_seen = 0;
    int               done_seen = 0;
    int               invalid_seen = 0;
    int               toosmall_seen = 0;
    int               cycle_count;
    u8u16_pkg::t_item head;
    int               queued_prior;

    // ------------------------------------------------------------------
    // clock, and the cycle limit that ends a stuck run
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_count,
                 utf16_expected.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [15:0] shown_units(input logic [32:0] c);
        shown_units = (c > 33'd65535) ? 16'hffff : c[15:0];
    endfunction

    function automatic u8u16_pkg::t_item make_item(input logic [15:0] cu,
                                                   input logic [20:0] sc,
                                                   input logic [2:0] sb,
                                                   input u8u16_pkg::t_status st,
                                                   input logic [15:0] tot, input logic lst);
        u8u16_pkg::t_item it;
        it.code_unit  = cu;
        it.scalar     = sc;
        it.seq_bytes  = sb;
        it.status     = st;
        it.unit_total = tot;
        it.last       = lst;
        make_item = it;
    endfunction

    task automatic clear_text();
        acc          = '0;
        left         = '0;
        lead         = '0;
        slen         = '0;
        ucount       = '0;
        failed_text  = 1'b0;
        dropped_text = 1'b0;
    endtask

    // first bad byte of a text: one error item, then silence until the end marker
    task automatic flag_invalid();
        failed_text = 1'b1;
        left        = '0;
        slen        = '0;
        acc         = '0;
        utf16_expected.push_back(make_item('0, '0, '0, u8u16_pkg::ST_INVALID,
                                           shown_units(ucount), 1'b1));
    endtask

    // a scalar is complete: count its units and emit them if they fit
    task automatic close_scalar(input logic [20:0] sc, input logic [2:0] nb);
        logic [32:0] units;
        logic [32:0] after_one;
        logic [32:0] after_all;
        logic [20:0] adj;
        bit          fits;
        left = '0;
        slen = '0;
        acc  = '0;
        if (sc > UNICODE_MAX || (sc >= SURROGATE_FIRST && sc <= SURROGATE_LAST)) begin
            flag_invalid();
        end else begin
            units     = (sc > BMP_LAST) ? 33'd2 : 33'd1;
            fits      = (ucount + units) <= {17'd0, cap_reg};
            after_one = (ucount + 33'd1 > COUNT_LIMIT) ? COUNT_LIMIT : ucount + 33'd1;
            after_all = (ucount + units > COUNT_LIMIT) ? COUNT_LIMIT : ucount + units;
            ucount    = after_all;
            if (!fits) begin
                dropped_text = 1'b1;
            end
            if (xcode_en && fits) begin
                if (units == 33'd1) begin
                    utf16_expected.push_back(make_item(sc[15:0], sc, nb, u8u16_pkg::ST_UNIT,
                                                       shown_units(after_one), 1'b1));
                end else begin
                    // high surrogate first, low surrogate closes the item
                    adj = sc - PLANE1_START;
                    utf16_expected.push_back(make_item({6'b110110, adj[19:10]}, sc, nb,
                                                       u8u16_pkg::ST_UNIT,
                                                       shown_units(after_one), 1'b0));
                    utf16_expected.push_back(make_item({6'b110111, adj[9:0]}, sc, nb,
                                                       u8u16_pkg::ST_UNIT,
                                                       shown_units(after_all), 1'b1));
                end
            end
        end
    endtask

    task automatic decode_utf8_item(input logic k, input logic [7:0] b);
        u8u16_pkg::t_status st;
        if (k == u8u16_pkg::KIND_END) begin
            // end marker after an error only rearms
            if (!failed_text) begin
                if (left != 2'd0) begin
                    st = u8u16_pkg::ST_INVALID;
                end else if (dropped_text && xcode_en) begin
                    st = u8u16_pkg::ST_TOOSMALL;
                end else begin
                    st = u8u16_pkg::ST_DONE;
                end
                utf16_expected.push_back(make_item('0, '0, '0, st, shown_units(ucount), 1'b1));
            end
            clear_text();
        end else if (!failed_text) begin
            if (left == 2'd0) begin
                if (b <= 8'h7f) begin
                    close_scalar({13'd0, b}, 3'd1);
                end else if (b >= 8'hc2 && b <= 8'hdf) begin
                    slen = 3'd2;
                    acc  = {16'd0, b[4:0]};
                    lead = b;
                    left = 2'd1;
                end else if (b >= 8'he0 && b <= 8'hef) begin
                    slen = 3'd3;
                    acc  = {17'd0, b[3:0]};
                    lead = b;
                    left = 2'd2;
                end else if (b >= 8'hf0 && b <= 8'hf4) begin
                    slen = 3'd4;
                    acc  = {18'd0, b[2:0]};
                    lead = b;
                    left = 2'd3;
                end else begin
                    flag_invalid();
                end
            end else if (b[7:6] != 2'b10) begin
                flag_invalid();
            end else if ((slen - left == 1) &&
                         ((lead == 8'he0 && b < 8'ha0) || (lead == 8'hed && b >= 8'ha0) ||
                          (lead == 8'hf0 && b < 8'h90) || (lead == 8'hf4 && b >= 8'h90))) begin
                // second byte rules: overlong, surrogate and above-limit forms
                flag_invalid();
            end else begin
                acc  = {acc[14:0], b[5:0]};
                left = left - 2'd1;
                if (left == 2'd0) begin
                    close_scalar(acc, slen);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // scoreboard: check results, then predict from the item taken
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("%0t result %0d: %s got %0h expected %0h", $time, results_seen, what,
                     got, want);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (utf16_expected.size() == 0) begin
                    report_mismatch("result with nothing due, status", 32'(o_status), 32'd0);
                end else begin
                    head = utf16_expected.pop_front();
                    case (head.status)
                        u8u16_pkg::ST_UNIT:    units_seen++;
                        u8u16_pkg::ST_DONE:    done_seen++;
                        u8u16_pkg::ST_INVALID: invalid_seen++;
                        default:               toosmall_seen++;
                    endcase
                    if (o_code_unit !== head.code_unit)
                        report_mismatch("code_unit", 32'(o_code_unit), 32'(head.code_unit));
                    if (o_scalar !== head.scalar)
                        report_mismatch("scalar", 32'(o_scalar), 32'(head.scalar));
                    if (o_seq_bytes !== head.seq_bytes)
                        report_mismatch("seq_bytes", 32'(o_seq_bytes), 32'(head.seq_bytes));
                    if (o_status !== head.status)
                        report_mismatch("status", 32'(o_status), 32'(head.status));
                    if (o_unit_total !== head.unit_total)
                        report_mismatch("unit_total", 32'(o_unit_total),
                                        32'(head.unit_total));
                    if (o_last !== head.last)
                        report_mismatch("last", 32'(o_last), 32'(head.last));
                end
            end
            if (i_valid && !o_stall) begin
                items_taken++;
                queued_prior = utf16_expected.size();
                decode_utf8_item(i_kind, i_in_byte);
                if (row_typed) begin
                    // the table row states its own answer for this item
                    while (utf16_expected.size() > queued_prior) begin
                        void'(utf16_expected.pop_back());
                    end
                    utf16_expected.push_back(row_want);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall bursts, and one long hold-off
    // ------------------------------------------------------------------
    initial begin
        int c;
        int burst;
        bit hold_done;
        i_stall   = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_stall <= 1'b1;
                for (c = 0; c < LONG_HOLD; c++) begin
                    @(negedge i_clk);
                end
                i_stall <= 1'b0;
                hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                burst = $urandom_range(1, 18);
                i_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side tasks, all entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic send_item(input logic k, input logic [7:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= k;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == u8u16_pkg::CFG_CAPACITY) begin
            cap_reg = val;
        end else begin
            xcode_en = val[0];
        end
        @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [15:0] cap, input logic en);
        write_reg(u8u16_pkg::CFG_CAPACITY, cap);
        // upper data bits of the enable write carry noise
        write_reg(u8u16_pkg::CFG_ENABLE, {15'($urandom), en});
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // the sender waits until every result is out, then lets the queue settle
    task automatic wait_drained();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (utf16_expected.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic int encode_utf8(input logic [20:0] sc, output logic [3:0][7:0] seq);
        seq = '0;
        if (sc < 21'h80) begin
            seq[0] = sc[7:0];
            encode_utf8 = 1;
        end else if (sc < 21'h800) begin
            seq[0] = {3'b110, sc[10:6]};
            seq[1] = {2'b10, sc[5:0]};
            encode_utf8 = 2;
        end else if (sc < 21'h10000) begin
            seq[0] = {4'b1110, sc[15:12]};
            seq[1] = {2'b10, sc[11:6]};
            seq[2] = {2'b10, sc[5:0]};
            encode_utf8 = 3;
        end else begin
            seq[0] = {5'b11110, sc[20:18]};
            seq[1] = {2'b10, sc[17:12]};
            seq[2] = {2'b10, sc[11:6]};
            seq[3] = {2'b10, sc[5:0]};
            encode_utf8 = 4;
        end
    endfunction

    // mostly valid scalars of every length, some boundaries, a few surrogates
    function automatic logic [20:0] pick_scalar();
        logic [20:0] v;
        case ($urandom_range(0, 10))
            0, 1, 2: v = 21'($urandom_range(0, 'h7f));
            3, 4:    v = 21'($urandom_range('h80, 'h7ff));
            5, 6: begin
                v = 21'($urandom_range('h800, 'hffff));
                if (v >= SURROGATE_FIRST && v <= SURROGATE_LAST) v = v ^ 21'h2000;
            end
            7, 8:    v = 21'($urandom_range('h10000, 'h10ffff));
            9: begin
                case ($urandom_range(0, 10))
                    0:       v = 21'h0;
                    1:       v = 21'h7f;
                    2:       v = 21'h80;
                    3:       v = 21'h7ff;
                    4:       v = 21'h800;
                    5:       v = 21'hd7ff;
                    6:       v = 21'he000;
                    7:       v = 21'hffff;
                    8:       v = 21'h10000;
                    9:       v = 21'hfffd;
                    default: v = 21'h10ffff;
                endcase
            end
            default: v = 21'($urandom_range('hd800, 'hdfff));
        endcase
        pick_scalar = v;
    endfunction

    // one text: random scalars with rare cuts, corrupt and stray bytes
    task automatic send_text();
        int               n;
        int               i;
        int               j;
        int               nb;
        logic [20:0]      sc;
        logic [3:0][7:0]  seq;
        logic [7:0]       b;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
        for (i = 0; i < n; i++) begin
            sc = pick_scalar();
            nb = encode_utf8(sc, seq);
            if ($urandom_range(0, 39) == 0) nb = $urandom_range(1, nb);
            for (j = 0; j < nb; j++) begin
                b = seq[j];
                if ($urandom_range(0, 79) == 0) b = 8'($urandom);
                send_item(u8u16_pkg::KIND_BYTE, b);
            end
            if ($urandom_range(0, 59) == 0) send_item(u8u16_pkg::KIND_BYTE, 8'($urandom));
        end
        // now and then the text runs on into the next one
        if ($urandom_range(0, 11) != 0) send_item(u8u16_pkg::KIND_END, 8'($urandom));
        texts_sent++;
    endtask

    function automatic t_row step_row(input logic k, input logic [7:0] d);
        t_row r;
        r.kind  = k;
        r.data  = d;
        r.typed = 1'b0;
        r.want  = '0;
        step_row = r;
    endfunction

    function automatic t_row known_row(input logic k, input logic [7:0] d,
                                       input logic [15:0] cu, input logic [20:0] sc,
                                       input logic [2:0] sb, input u8u16_pkg::t_status st,
                                       input logic [15:0] tot);
        t_row r;
        r       = step_row(k, d);
        r.typed = 1'b1;
        r.want  = make_item(cu, sc, sb, st, tot, 1'b1);
        known_row = r;
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_row             dir_rows[$];
        int               p;
        int               goal;
        logic [15:0]      cap_val;
        logic             en_val;
        u8u16_pkg::t_item rest;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_kind      = u8u16_pkg::KIND_BYTE;
        i_in_byte   = 8'h00;
        i_cfg_valid = 1'b0;
        i_cfg_index = u8u16_pkg::CFG_CAPACITY;
        i_cfg_data  = 16'h0000;

        // ascii extremes right after reset, then a stray continuation byte
        dir_rows.push_back(known_row(u8u16_pkg::KIND_BYTE, 8'h00, 16'h0000, 21'h00, 3'd1,
                                     u8u16_pkg::ST_UNIT, 16'd1));
        dir_rows.push_back(known_row(u8u16_pkg::KIND_BYTE, 8'h7f, 16'h007f, 21'h7f, 3'd1,
                                     u8u16_pkg::ST_UNIT, 16'd2));
        dir_rows.push_back(known_row(u8u16_pkg::KIND_BYTE, 8'h80, 16'h0000, 21'h00, 3'd0,
                                     u8u16_pkg::ST_INVALID, 16'd2));
        // bytes after the error are dropped, the end marker only rearms
        dir_rows.push_back(step_row(u8u16_pkg::KIND_BYTE, 8'h41));
        dir_rows.push_back(step_row(u8u16_pkg::KIND_END, 8'hff));
        // smallest two-byte, largest three-byte, largest four-byte scalar
        dir_rows.push_back(step_row(u8u16_pkg::KIND_BYTE, 8'hc2));
        dir_rows.push_back(known_row(u8u16_pkg::KIND_BYTE, 8'h80, 16'h0080, 21'h80, 3'd2,
                                     u8u16_pkg::ST_UNIT, 16'd1));
        dir_rows.push_back(step_row(u8u16_pkg::KIND_BYTE, 8'hef));
        dir_rows.push_back(step_row(u8u16_pkg::KIND_BYTE, 8'hbf));
        dir_rows.push_back(known_row(u8u16_pkg::KIND_BYTE, 8'hbf, 16'hffff, 21'hffff, 3'd3,
                                     u8u16_pkg::ST_UNIT, 16'd2));
        dir_rows.push_back(step_row(u8u16_pkg::KIND_BYTE, 8'hf4));
        dir_rows.push_back(step_row(u8u16_pkg::KIND_BYTE, 8'h8f));
        dir_rows.push_back(step_row(u8u16_pkg::KIND_BYTE, 8'hbf));
        dir_rows.push_back(step_row(u8u16_pkg::KIND_BYTE, 8'hbf));
        dir_rows.push_back(known_row(u8u16_pkg::KIND_END, 8'h00, 16'h0000, 21'h00, 3'd0,
                                     u8u16_pkg::ST_DONE, 16'd4));
        // overlong three-byte form
        dir_rows.push_back(step_row(u8u16_pkg::KIND_BYTE, 8'he0));
        dir_rows.push_back(known_row(u8u16_pkg::KIND_BYTE, 8'h9f, 16'h0000, 21'h00, 3'd0,
                                     u8u16_pkg::ST_INVALID, 16'd0));
        dir_rows.push_back(step_row(u8u16_pkg::KIND_END, 8'h00));
        // encoded surrogate
        dir_rows.push_back(step_row(u8u16_pkg::KIND_BYTE, 8'hed));
        dir_rows.push_back(known_row(u8u16_pkg::KIND_BYTE, 8'ha0, 16'h0000, 21'h00, 3'd0,
                                     u8u16_pkg::ST_INVALID, 16'd0));
        dir_rows.push_back(step_row(u8u16_pkg::KIND_END, 8'h00));
        // above the unicode limit
        dir_rows.push_back(step_row(u8u16_pkg::KIND_BYTE, 8'hf4));
        dir_rows.push_back(known_row(u8u16_pkg::KIND_BYTE, 8'h90, 16'h0000, 21'h00, 3'd0,
                                     u8u16_pkg::ST_INVALID, 16'd0));
        dir_rows.push_back(step_row(u8u16_pkg::KIND_END, 8'h00));
        // sequence cut short by the end marker
        dir_rows.push_back(step_row(u8u16_pkg::KIND_BYTE, 8'he2));
        dir_rows.push_back(step_row(u8u16_pkg::KIND_BYTE, 8'h82));
        dir_rows.push_back(known_row(u8u16_pkg::KIND_END, 8'h00, 16'h0000, 21'h00, 3'd0,
                                     u8u16_pkg::ST_INVALID, 16'd0));

        // synchronous reset, released at a falling edge
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table at reset settings
        idle_on = 1'b1;
        foreach (dir_rows[k]) begin
            row_typed = dir_rows[k].typed;
            row_want  = dir_rows[k].want;
            send_item(dir_rows[k].kind, dir_rows[k].data);
        end
        row_typed = 1'b0;
        wait_drained();

        // random texts under a series of register settings
        for (p = 0; p < 8; p++) begin
            case (p)
                0:       begin cap_val = 16'hffff;                   en_val = 1'b1; end
                1:       begin cap_val = 16'h0000;                   en_val = 1'b1; end
                2:       begin cap_val = 16'd5;                      en_val = 1'b1; end
                3:       begin cap_val = 16'($urandom_range(1, 24)); en_val = 1'b1; end
                4:       begin cap_val = 16'h0000;                   en_val = 1'b0; end
                5:       begin cap_val = 16'hffff;                   en_val = 1'b0; end
                6:       begin cap_val = 16'($urandom);              en_val = 1'b1; end
                default: begin cap_val = 16'd2;                      en_val = 1'b1; end
            endcase
            set_regs(cap_val, en_val);
            // one setting runs with no idling at all
            idle_on = (p != 2);
            // the first setting starts with a long receiver hold-off
            if (p == 0) hold_req = 1'b1;
            goal = items_taken + PHASE_ITEMS;
            while (items_taken < goal) begin
                send_text();
            end
            wait_drained();
        end

        // last part, no idling, full capacity
        idle_on = 1'b0;
        set_regs(16'hffff, 1'b1);
        goal = items_taken + LAST_ITEMS;
        while (items_taken < goal) begin
            send_text();
        end
        wait_drained();

        while (utf16_expected.size() != 0) begin
            rest = utf16_expected.pop_front();
            report_mismatch("missing result, status", 32'(rest.status), 32'(rest.status));
        end

        $display("%0d items in %0d texts under %0d register settings, %0d results checked",
                 items_taken, texts_sent, settings_used, results_seen);
        $display("units %0d, done %0d, invalid %0d, buffer too small %0d, mismatches %0d",
                 units_seen, done_seen, invalid_seen, toosmall_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
